### rtl/w2r_pkg.sv
// ----------------------------------------------------------------------------
// w2r_pkg - shared constants and types of the wavelength to RGB converter
// Fixed-point formats, band edges, reciprocal constants and stage records.
// ----------------------------------------------------------------------------
package w2r_pkg;

    // Fraction bits of the part, factor and product values (1.0 = 2^FRACTION_BITS)
    localparam int FRACTION_BITS = 16;
    localparam int GAIN_FRAC     = 12;

    localparam int WL_W   = 14;
    localparam int GAIN_W = 16;
    localparam int CH_W   = 8;
    localparam int LANES  = 3;

    localparam int LANE_R = 0;
    localparam int LANE_G = 1;
    localparam int LANE_B = 2;

    localparam int S_TDATA_W = ((WL_W + GAIN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((LANES * CH_W + 7) / 8) * 8;

    // Q0.FRACTION_BITS values up to and including 1.0
    localparam int Q_W   = FRACTION_BITS + 1;
    // Band numerators never exceed 21600
    localparam int NUM_W = 15;
    localparam int DEN_W = 15;
    // Scaled dividend of the constant divisions and its reciprocal width
    localparam int X_W   = FRACTION_BITS + NUM_W;
    localparam int R_W   = X_W - 8;
    // part * factor * gain
    localparam int PG_W  = Q_W + GAIN_W;
    // Scaling divider: dividend 510 * pf + pf_max, divisor 2 * pf_max
    localparam int N_W   = FRACTION_BITS + 9;
    localparam int D_W   = Q_W + 1;
    // One quotient bit per divider stage
    localparam int DIV_STEPS = CH_W;

    // Half an LSB of the part times factor product, for round to nearest
    localparam logic [2*Q_W-1:0] HALF_PF = (2*Q_W)'(1) << (FRACTION_BITS - 1);
    // Full scale of part * factor * gain, before the factor of 255
    localparam logic [PG_W-1:0]  LIM_PG  = PG_W'(1) << (FRACTION_BITS + GAIN_FRAC);

    // Wavelength limits and band edges in 1/16 nm
    localparam logic [WL_W-1:0] WL_LO = 14'd6080;
    localparam logic [WL_W-1:0] WL_HI = 14'd12480;
    localparam logic [WL_W-1:0] WL_F1 = 14'd6720;
    localparam logic [WL_W-1:0] WL_B1 = 14'd7040;
    localparam logic [WL_W-1:0] WL_B2 = 14'd7840;
    localparam logic [WL_W-1:0] WL_B3 = 14'd8160;
    localparam logic [WL_W-1:0] WL_B4 = 14'd9280;
    localparam logic [WL_W-1:0] WL_B5 = 14'd10320;

    // Intensity ramp offsets: three times each ramp length, 0.3 of its divisor
    localparam logic [NUM_W-1:0] FAC_LO_BASE = 15'd1920;
    localparam logic [NUM_W-1:0] FAC_HI_BASE = 15'd6480;

    localparam logic [DEN_W-1:0] DEN_B1  = 15'd960;
    localparam logic [DEN_W-1:0] DEN_B2  = 15'd800;
    localparam logic [DEN_W-1:0] DEN_B3  = 15'd320;
    localparam logic [DEN_W-1:0] DEN_B4  = 15'd1120;
    localparam logic [DEN_W-1:0] DEN_B5  = 15'd1040;
    localparam logic [DEN_W-1:0] DEN_FLO = 15'd6400;
    localparam logic [DEN_W-1:0] DEN_FHI = 15'd21600;

    // floor(2^X_W / den): the estimate is low by at most one
    localparam logic [R_W-1:0] RCP_B1  = R_W'((64'd1 << X_W) / DEN_B1);
    localparam logic [R_W-1:0] RCP_B2  = R_W'((64'd1 << X_W) / DEN_B2);
    localparam logic [R_W-1:0] RCP_B3  = R_W'((64'd1 << X_W) / DEN_B3);
    localparam logic [R_W-1:0] RCP_B4  = R_W'((64'd1 << X_W) / DEN_B4);
    localparam logic [R_W-1:0] RCP_B5  = R_W'((64'd1 << X_W) / DEN_B5);
    localparam logic [R_W-1:0] RCP_FLO = R_W'((64'd1 << X_W) / DEN_FLO);
    localparam logic [R_W-1:0] RCP_FHI = R_W'((64'd1 << X_W) / DEN_FHI);

    localparam logic [Q_W-1:0]  ONE_Q  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    typedef enum logic [1:0] {
        PART_ZERO,
        PART_ONE,
        PART_DIV
    } part_kind_t;

    typedef logic [LANES-1:0][CH_W-1:0] rgb_t;

    // Base parts and intensity factor of one item
    typedef struct packed {
        logic                       black;
        logic [GAIN_W-1:0]          gain;
        logic [LANES-1:0][Q_W-1:0]  part;
        logic [Q_W-1:0]             fac;
    } front_t;

    // Operands for the scaling divider and the truncated channels
    typedef struct packed {
        logic                       black;
        logic                       scale;
        logic [LANES-1:0][CH_W-1:0] trunc;
        logic [LANES-1:0][N_W-1:0]  num;
        logic [D_W-1:0]             den;
    } mix_t;

endpackage

### rtl/w2r_front.sv
// ----------------------------------------------------------------------------
// w2r_front - band decode and constant divisions
// Four stages: decode, reciprocal multiply, back multiply, correct and select.
// ----------------------------------------------------------------------------
module w2r_front
    import w2r_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [WL_W-1:0]   wavelength,
    input  logic [GAIN_W-1:0] gain,
    output logic              dn_valid,
    input  logic              dn_ready,
    output front_t            dn_data
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // Stage 1
    logic              black1_reg, black_next;
    logic [GAIN_W-1:0] gain1_reg;
    part_kind_t        kind1_reg [LANES];
    part_kind_t        kind_next [LANES];
    logic              fone1_reg, fone_next;
    logic [X_W-1:0]    xp1_reg, xp_next, xf1_reg, xf_next;
    logic [R_W-1:0]    rp1_reg, rp_next, rf1_reg, rf_next;
    logic [DEN_W-1:0]  dp1_reg, dp_next, df1_reg, df_next;
    logic [NUM_W-1:0]  wl_ext, num_p, num_f, dwf;

    // Stage 2
    logic              black2_reg;
    logic [GAIN_W-1:0] gain2_reg;
    part_kind_t        kind2_reg [LANES];
    logic              fone2_reg;
    logic [X_W-1:0]    xp2_reg, xf2_reg;
    logic [DEN_W-1:0]  dp2_reg, df2_reg;
    logic [Q_W-1:0]    qp2_reg, qf2_reg;
    logic [X_W+R_W-1:0] prod_p, prod_f;

    // Stage 3
    logic              black3_reg;
    logic [GAIN_W-1:0] gain3_reg;
    part_kind_t        kind3_reg [LANES];
    logic              fone3_reg;
    logic [X_W-1:0]    xp3_reg, xf3_reg, mp3_reg, mf3_reg;
    logic [DEN_W-1:0]  dp3_reg, df3_reg;
    logic [Q_W-1:0]    qp3_reg, qf3_reg;
    logic [Q_W+DEN_W-1:0] back_p, back_f;

    // Stage 4
    logic [X_W-1:0]    rem_p, rem_f;
    logic [Q_W-1:0]    qp_fix, qf_fix;
    front_t            out_reg, out_next;

    assign en4      = !v4_reg || dn_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign up_ready = en1;
    assign dn_valid = v4_reg;
    assign dn_data  = out_reg;

    assign wl_ext = NUM_W'(wavelength);

    // Decode the band: which channel ramps, and the ramp's numerator and divisor
    always_comb
    begin
        black_next = (wavelength < WL_LO) || (wavelength > WL_HI) || (gain == '0);
        for (int i = 0; i < LANES; i++)
        begin
            kind_next[i] = PART_ZERO;
        end
        num_p   = '0;
        dp_next = DEN_B1;
        rp_next = RCP_B1;
        if (wavelength < WL_B1)
        begin
            kind_next[LANE_R] = PART_DIV;
            kind_next[LANE_B] = PART_ONE;
            num_p   = NUM_W'(WL_B1) - wl_ext;
            dp_next = DEN_B1;
            rp_next = RCP_B1;
        end
        else if (wavelength < WL_B2)
        begin
            kind_next[LANE_G] = PART_DIV;
            kind_next[LANE_B] = PART_ONE;
            num_p   = wl_ext - NUM_W'(WL_B1);
            dp_next = DEN_B2;
            rp_next = RCP_B2;
        end
        else if (wavelength < WL_B3)
        begin
            kind_next[LANE_G] = PART_ONE;
            kind_next[LANE_B] = PART_DIV;
            num_p   = NUM_W'(WL_B3) - wl_ext;
            dp_next = DEN_B3;
            rp_next = RCP_B3;
        end
        else if (wavelength < WL_B4)
        begin
            kind_next[LANE_R] = PART_DIV;
            kind_next[LANE_G] = PART_ONE;
            num_p   = wl_ext - NUM_W'(WL_B3);
            dp_next = DEN_B4;
            rp_next = RCP_B4;
        end
        else if (wavelength < WL_B5)
        begin
            kind_next[LANE_R] = PART_ONE;
            kind_next[LANE_G] = PART_DIV;
            num_p   = NUM_W'(WL_B5) - wl_ext;
            dp_next = DEN_B5;
            rp_next = RCP_B5;
        end
        else
        begin
            kind_next[LANE_R] = PART_ONE;
        end

        // Intensity: 0.3 + 0.7 * ramp position at either end of the spectrum
        fone_next = 1'b0;
        dwf       = '0;
        num_f     = '0;
        df_next   = DEN_FLO;
        rf_next   = RCP_FLO;
        if (wavelength < WL_F1)
        begin
            dwf     = wl_ext - NUM_W'(WL_LO);
            num_f   = FAC_LO_BASE + (dwf << 3) - dwf;
            df_next = DEN_FLO;
            rf_next = RCP_FLO;
        end
        else if (wavelength < WL_B5)
        begin
            fone_next = 1'b1;
        end
        else
        begin
            dwf     = NUM_W'(WL_HI) - wl_ext;
            num_f   = FAC_HI_BASE + (dwf << 3) - dwf;
            df_next = DEN_FHI;
            rf_next = RCP_FHI;
        end

        // Scale up and add half the divisor for round to nearest
        xp_next = (X_W'(num_p) << FRACTION_BITS) + X_W'(dp_next >> 1);
        xf_next = (X_W'(num_f) << FRACTION_BITS) + X_W'(df_next >> 1);
    end

    assign prod_p = {{R_W{1'b0}}, xp1_reg} * {{X_W{1'b0}}, rp1_reg};
    assign prod_f = {{R_W{1'b0}}, xf1_reg} * {{X_W{1'b0}}, rf1_reg};

    assign back_p = {{DEN_W{1'b0}}, qp2_reg} * {{Q_W{1'b0}}, dp2_reg};
    assign back_f = {{DEN_W{1'b0}}, qf2_reg} * {{Q_W{1'b0}}, df2_reg};

    // Bump the estimate where the remainder still holds a whole divisor
    always_comb
    begin
        rem_p  = xp3_reg - mp3_reg;
        rem_f  = xf3_reg - mf3_reg;
        qp_fix = qp3_reg + Q_W'(rem_p >= X_W'(dp3_reg));
        qf_fix = qf3_reg + Q_W'(rem_f >= X_W'(df3_reg));
        out_next.black = black3_reg;
        out_next.gain  = gain3_reg;
        out_next.fac   = fone3_reg ? ONE_Q : qf_fix;
        for (int i = 0; i < LANES; i++)
        begin
            case (kind3_reg[i])
                PART_ONE: out_next.part[i] = ONE_Q;
                PART_DIV: out_next.part[i] = qp_fix;
                default:  out_next.part[i] = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= up_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            black1_reg <= black_next;
            gain1_reg  <= gain;
            kind1_reg  <= kind_next;
            fone1_reg  <= fone_next;
            xp1_reg    <= xp_next;
            rp1_reg    <= rp_next;
            dp1_reg    <= dp_next;
            xf1_reg    <= xf_next;
            rf1_reg    <= rf_next;
            df1_reg    <= df_next;
        end
        if (en2)
        begin
            black2_reg <= black1_reg;
            gain2_reg  <= gain1_reg;
            kind2_reg  <= kind1_reg;
            fone2_reg  <= fone1_reg;
            xp2_reg    <= xp1_reg;
            dp2_reg    <= dp1_reg;
            xf2_reg    <= xf1_reg;
            df2_reg    <= df1_reg;
            qp2_reg    <= Q_W'(prod_p >> X_W);
            qf2_reg    <= Q_W'(prod_f >> X_W);
        end
        if (en3)
        begin
            black3_reg <= black2_reg;
            gain3_reg  <= gain2_reg;
            kind3_reg  <= kind2_reg;
            fone3_reg  <= fone2_reg;
            xp3_reg    <= xp2_reg;
            dp3_reg    <= dp2_reg;
            xf3_reg    <= xf2_reg;
            df3_reg    <= df2_reg;
            qp3_reg    <= qp2_reg;
            qf3_reg    <= qf2_reg;
            mp3_reg    <= X_W'(back_p);
            mf3_reg    <= X_W'(back_f);
        end
        if (en4)
        begin
            out_reg <= out_next;
        end
    end

endmodule

### rtl/w2r_mix.sv
// ----------------------------------------------------------------------------
// w2r_mix - apply intensity and gain, find the peak channel
// Three stages: part times factor, times gain, overflow test and operands.
// ----------------------------------------------------------------------------
module w2r_mix
    import w2r_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  front_t up_data,
    output logic   dn_valid,
    input  logic   dn_ready,
    output mix_t   dn_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic                       black1_reg, black2_reg;
    logic [GAIN_W-1:0]          gain1_reg;
    logic [2*Q_W-1:0]           prod_pf [LANES];
    logic [LANES-1:0][Q_W-1:0]  pf_next, pf1_reg, pf2_reg;
    logic [LANES-1:0][PG_W-1:0] pg_next, pg2_reg;
    logic [Q_W-1:0]             pfm_next, pfm2_reg;
    logic [PG_W-1:0]            pgm;
    logic [PG_W+CH_W-1:0]       ch255;
    logic [PG_W+CH_W-1:0]       tr;
    mix_t                       out_reg, out_next;

    assign en3      = !v3_reg || dn_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign up_ready = en1;
    assign dn_valid = v3_reg;
    assign dn_data  = out_reg;

    // Round part times factor back to the Q0 scale
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod_pf[i] = {{Q_W{1'b0}}, up_data.part[i]} * {{Q_W{1'b0}}, up_data.fac};
            pf_next[i] = Q_W'((prod_pf[i] + HALF_PF) >> FRACTION_BITS);
        end
    end

    always_comb
    begin
        pfm_next = pf1_reg[LANE_R];
        if (pf1_reg[LANE_G] > pfm_next) pfm_next = pf1_reg[LANE_G];
        if (pf1_reg[LANE_B] > pfm_next) pfm_next = pf1_reg[LANE_B];
        for (int i = 0; i < LANES; i++)
        begin
            pg_next[i] = {{GAIN_W{1'b0}}, pf1_reg[i]} * {{Q_W{1'b0}}, gain1_reg};
        end
    end

    // Scale only when the brightest channel passes full scale; 255 and the
    // gain cancel out of the scaling ratio, so divide on the pf values alone
    always_comb
    begin
        pgm = pg2_reg[LANE_R];
        if (pg2_reg[LANE_G] > pgm) pgm = pg2_reg[LANE_G];
        if (pg2_reg[LANE_B] > pgm) pgm = pg2_reg[LANE_B];
        out_next.black = black2_reg;
        out_next.scale = pgm > LIM_PG;
        out_next.den   = {pfm2_reg, 1'b0};
        ch255 = '0;
        tr    = '0;
        for (int i = 0; i < LANES; i++)
        begin
            ch255 = {pg2_reg[i], {CH_W{1'b0}}} - (PG_W+CH_W)'(pg2_reg[i]);
            tr    = ch255 >> (FRACTION_BITS + GAIN_FRAC);
            out_next.trunc[i] = (tr > (PG_W+CH_W)'(CH_MAX)) ? CH_MAX : tr[CH_W-1:0];
            // 510 * pf + pf_max
            out_next.num[i] = (N_W'(pf2_reg[i]) << 9) - (N_W'(pf2_reg[i]) << 1)
                              + N_W'(pfm2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= up_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            black1_reg <= up_data.black;
            gain1_reg  <= up_data.gain;
            pf1_reg    <= pf_next;
        end
        if (en2)
        begin
            black2_reg <= black1_reg;
            pf2_reg    <= pf1_reg;
            pg2_reg    <= pg_next;
            pfm2_reg   <= pfm_next;
        end
        if (en3)
        begin
            out_reg <= out_next;
        end
    end

endmodule

### rtl/w2r_div.sv
// ----------------------------------------------------------------------------
// w2r_div - pipelined scaling divider and output register
// One quotient bit per stage for all three channels, then the final select.
// ----------------------------------------------------------------------------
module w2r_div
    import w2r_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  mix_t up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output rgb_t dn_data
);

    typedef struct packed {
        logic                       black;
        logic                       scale;
        logic [LANES-1:0][CH_W-1:0] trunc;
        logic [LANES-1:0][N_W-1:0]  rem;
        logic [LANES-1:0][CH_W-1:0] quo;
        logic [D_W-1:0]             den;
    } div_stage_t;

    div_stage_t           stg_in   [DIV_STEPS];
    div_stage_t           stg_next [DIV_STEPS];
    div_stage_t           stg_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;
    logic [DIV_STEPS-1:0] vld_in;
    logic [DIV_STEPS:0]   en;
    logic                 out_vld_reg;
    rgb_t                 out_reg, out_next;
    logic [N_W-1:0]       sub;

    assign up_ready = en[0];
    assign dn_valid = out_vld_reg;
    assign dn_data  = out_reg;

    // Advance a stage when it is empty or the one after it moves
    always_comb
    begin
        en[DIV_STEPS] = !out_vld_reg || dn_ready;
        for (int k = DIV_STEPS - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_in = {vld_reg[DIV_STEPS-2:0], up_valid};

    always_comb
    begin
        stg_in[0].black = up_data.black;
        stg_in[0].scale = up_data.scale;
        stg_in[0].trunc = up_data.trunc;
        stg_in[0].rem   = up_data.num;
        stg_in[0].quo   = '0;
        stg_in[0].den   = up_data.den;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            stg_in[k] = stg_reg[k-1];
        end
    end

    // Restoring step: take the shifted divisor off where it fits
    always_comb
    begin
        sub = '0;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            stg_next[k] = stg_in[k];
            for (int i = 0; i < LANES; i++)
            begin
                sub = N_W'(stg_in[k].den) << (DIV_STEPS - 1 - k);
                if (stg_in[k].rem[i] >= sub)
                begin
                    stg_next[k].rem[i] = stg_in[k].rem[i] - sub;
                    stg_next[k].quo[i][DIV_STEPS-1-k] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (stg_reg[DIV_STEPS-1].black)
                out_next[i] = '0;
            else if (stg_reg[DIV_STEPS-1].scale)
                out_next[i] = stg_reg[DIV_STEPS-1].quo[i];
            else
                out_next[i] = stg_reg[DIV_STEPS-1].trunc[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                if (en[k]) vld_reg[k] <= vld_in[k];
            end
            if (en[DIV_STEPS]) out_vld_reg <= vld_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (en[k]) stg_reg[k] <= stg_next[k];
        end
        if (en[DIV_STEPS]) out_reg <= out_next;
    end

endmodule

### rtl/wavelength_to_rgb.sv
// ----------------------------------------------------------------------------
// wavelength_to_rgb - visible wavelength to 8-bit RGB colour converter
// Piecewise-linear spectrum with intensity roll-off and peak normalisation.
// ----------------------------------------------------------------------------
// Usage
//   Input beats arrive on the s_axis group: a wavelength in 1/16 nm and an
//   unsigned Q4.12 gain. Each input beat yields exactly one output beat on
//   the m_axis group carrying red, green and blue, in the same order.
//   A beat passes 16 register stages between s_axis and m_axis. The stages
//   are 4 of band decode and constant division, 3 of intensity and gain
//   multiplication, 8 of the one-bit-per-stage scaling divider and 1 of the
//   output register. Throughput is one beat per cycle while m_axis_tready
//   stays high, set by the fully pipelined datapath in which every stage
//   takes a new beat each cycle unless the next stage holds a stalled beat.
//   Wavelengths outside 380 nm to 780 nm and a zero gain give black.
//   Reset clears all stage valid bits; the pipe comes out of reset empty and
//   ready. When the receiver stalls, the output register holds its beat and
//   the stages behind it keep filling until each holds a beat, then
//   s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module wavelength_to_rgb
    import w2r_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [13:0] wavelength, [29:14] gain, [31:30] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic   front_valid, front_ready;
    front_t front_data;
    logic   mix_valid, mix_ready;
    mix_t   mix_data;
    rgb_t   rgb;

    // Band decode, ramp divisions by constants, part and factor selection
    w2r_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s_axis_tvalid),
        .up_ready   (s_axis_tready),
        .wavelength (s_axis_tdata[WL_W-1:0]),
        .gain       (s_axis_tdata[WL_W+GAIN_W-1:WL_W]),
        .dn_valid   (front_valid),
        .dn_ready   (front_ready),
        .dn_data    (front_data)
    );

    // Intensity and gain, peak detection, divider operands
    w2r_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_ready (front_ready),
        .up_data  (front_data),
        .dn_valid (mix_valid),
        .dn_ready (mix_ready),
        .dn_data  (mix_data)
    );

    // Normalise overdriven colours, zero black ones, otherwise pass the truncated channels
    w2r_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mix_valid),
        .up_ready (mix_ready),
        .up_data  (mix_data),
        .dn_valid (m_axis_tvalid),
        .dn_ready (m_axis_tready),
        .dn_data  (rgb)
    );

    // Pad the colour beat to whole bytes
    assign m_axis_tdata = M_TDATA_W'(rgb);

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the wavelength to RGB converter
// Drives wavelength/gain beats in random bursts, predicts every RGB triple in
// fixed point and checks each output beat in order, under random and long
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int S_W = w2r_pkg::S_TDATA_W;
    localparam int M_W = w2r_pkg::M_TDATA_W;

    // Fixed-point format of parts and factor; gain is Q4.12
    localparam int              FRAC_BITS = 16;
    localparam int              LEVEL_SHIFT = FRAC_BITS + 12;
    localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;
    localparam longint unsigned HALF_LSB = 64'd1 << (FRAC_BITS - 1);
    localparam longint unsigned BYTE_CEIL = 64'd255 << LEVEL_SHIFT;

    // Spectrum edges in 1/16 nm
    localparam int EDGE_380 = 6080;
    localparam int EDGE_420 = 6720;
    localparam int EDGE_440 = 7040;
    localparam int EDGE_490 = 7840;
    localparam int EDGE_510 = 8160;
    localparam int EDGE_580 = 9280;
    localparam int EDGE_645 = 10320;
    localparam int EDGE_780 = 12480;

    localparam int RED   = 0;
    localparam int GREEN = 1;
    localparam int BLUE  = 2;

    localparam int PIPE_LATENCY = 16;
    localparam int HOLD_CYCLES  = 400;

    typedef enum logic { RX_OPEN, RX_CHOPPY } rx_style_t;
    typedef enum logic { ITEM_SPECTRUM, ITEM_NOISE } item_style_t;

    typedef struct {
        logic [13:0]     wl;
        logic [15:0]     gain;
        w2r_pkg::rgb_t   rgb;
    } colour_expect_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [S_W-1:0] s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [M_W-1:0] m_axis_tdata;

    colour_expect_t colour_queue [$];
    int             mismatches = 0;
    rx_style_t      rx_style = RX_OPEN;
    logic           hold_req = 1'b0;
    string          lane_names [3] = '{"red", "green", "blue"};

    wavelength_to_rgb dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [13:0] wavelength, [29:14] gain, [31:30] zero
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [7:0] red, [15:8] green, [23:16] blue
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Colour predictor
    // ------------------------------------------------------------------------

    // num/den as an unsigned Q0.16 value, rounded half up
    function automatic longint unsigned q_ratio(longint unsigned num, longint unsigned den);
        return ((num << FRAC_BITS) + (den >> 1)) / den;
    endfunction

    function automatic w2r_pkg::rgb_t predict_rgb(logic [13:0] wl, logic [15:0] gain);
        longint unsigned w;
        longint unsigned g;
        longint unsigned fac;
        longint unsigned peak;
        longint unsigned v;
        longint unsigned part [3];
        longint unsigned level [3];
        w2r_pkg::rgb_t   rgb;
        w = 64'(wl);
        g = 64'(gain);
        rgb = '0;
        part = '{0, 0, 0};
        // Outside the visible range or no gain: black
        if (w < EDGE_380 || w > EDGE_780 || g == 0)
            return rgb;

        // Base parts per band, each band starting at its lower edge
        if (w < EDGE_440) begin
            part[RED]  = q_ratio(EDGE_440 - w, EDGE_440 - EDGE_380);
            part[BLUE] = UNIT;
        end
        else if (w < EDGE_490) begin
            part[GREEN] = q_ratio(w - EDGE_440, EDGE_490 - EDGE_440);
            part[BLUE]  = UNIT;
        end
        else if (w < EDGE_510) begin
            part[GREEN] = UNIT;
            part[BLUE]  = q_ratio(EDGE_510 - w, EDGE_510 - EDGE_490);
        end
        else if (w < EDGE_580) begin
            part[RED]   = q_ratio(w - EDGE_510, EDGE_580 - EDGE_510);
            part[GREEN] = UNIT;
        end
        else if (w < EDGE_645) begin
            part[RED]   = UNIT;
            part[GREEN] = q_ratio(EDGE_645 - w, EDGE_645 - EDGE_580);
        end
        else
            part[RED] = UNIT;

        // Intensity falls to 0.3 at both ends of the spectrum
        if (w < EDGE_420)
            fac = q_ratio(3 * (EDGE_420 - EDGE_380) + 7 * (w - EDGE_380),
                          10 * (EDGE_420 - EDGE_380));
        else if (w < EDGE_645)
            fac = UNIT;
        else
            fac = q_ratio(3 * (EDGE_780 - EDGE_645) + 7 * (EDGE_780 - w),
                          10 * (EDGE_780 - EDGE_645));

        peak = 0;
        for (int i = 0; i < 3; i++) begin
            level[i] = 64'd255 * ((part[i] * fac + HALF_LSB) >> FRAC_BITS) * g;
            if (level[i] > peak)
                peak = level[i];
        end

        // Normalise to the brightest channel when it overflows a byte
        for (int i = 0; i < 3; i++) begin
            if (peak > BYTE_CEIL)
                v = (64'd510 * level[i] + peak) / (64'd2 * peak);
            else
                v = level[i] >> LEVEL_SHIFT;
            if (v > 255)
                v = 255;
            rgb[i] = v[7:0];
        end
        return rgb;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side: every task starts and ends at a falling edge
    // ------------------------------------------------------------------------

    // Offer one beat, hold it until accepted, then record its colour
    task automatic send_beat(input logic [13:0] wl, input logic [15:0] gain);
        colour_expect_t item;
        item.wl   = wl;
        item.gain = gain;
        item.rgb  = predict_rgb(wl, gain);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, gain, wl};
        do
            @(posedge clk);
        while (!s_axis_tready);
        colour_queue.push_back(item);
        @(negedge clk);
    endtask

    // Drop valid for a while; scramble the data so nothing leaks through
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic pick_item(input item_style_t style, output logic [13:0] wl,
                             output logic [15:0] gain);
        int edges [8] = '{EDGE_380, EDGE_420, EDGE_440, EDGE_490,
                          EDGE_510, EDGE_580, EDGE_645, EDGE_780};
        int sel;
        if (style == ITEM_NOISE) begin
            wl   = 14'($urandom);
            gain = 16'($urandom);
            return;
        end
        sel = $urandom_range(0, 99);
        if (sel < 8)
            wl = 14'($urandom_range(0, EDGE_380 - 1));
        else if (sel < 16)
            wl = 14'($urandom_range(EDGE_780 + 1, 16383));
        else if (sel < 32)
            wl = 14'(edges[$urandom_range(0, 7)] + $urandom_range(0, 6) - 3);
        else
            wl = 14'($urandom_range(EDGE_380, EDGE_780));
        // Mix dim, near-unity and overdriven gains; overdrive forces scaling
        sel = $urandom_range(0, 99);
        if (sel < 5)
            gain = 16'd0;
        else if (sel < 30)
            gain = 16'($urandom_range(1, 1023));
        else if (sel < 55)
            gain = 16'($urandom_range(2048, 8192));
        else
            gain = 16'($urandom_range(1, 65535));
    endtask

    // Send beats in bursts of random length, with random gaps between them when max_gap is above zero
    task automatic send_stream(input int count, input item_style_t style, input int max_gap);
        logic [13:0] wl;
        logic [15:0] gain;
        int          burst;
        int          left;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
                pick_item(style, wl, gain);
                send_beat(wl, gain);
                burst--;
                left--;
            end
            if (max_gap > 0)
                pause_sender($urandom_range(0, max_gap));
        end
        pause_sender(1);
    endtask

    // Wait for every predicted colour, then let the pipe run dry
    task automatic wait_for_colours();
        while (colour_queue.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 8) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int        run_left;
        logic      run_ready;
        run_left  = 0;
        run_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                // Hold off long enough for the whole pipe to fill and back up
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (rx_style == RX_OPEN)
                m_axis_tready <= 1'b1;
            else begin
                if (run_left == 0) begin
                    run_ready = ~run_ready;
                    run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                run_left--;
                m_axis_tready <= run_ready;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output checker: compare each accepted beat with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : colour_check
        colour_expect_t item;
        w2r_pkg::rgb_t  got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[23:0];
            if (colour_queue.size() == 0) begin
                $display("%0t: unexpected output beat, expected none, got %h",
                         $time, got);
                mismatches++;
            end
            else begin
                item = colour_queue.pop_front();
                for (int i = 0; i < 3; i++)
                    if (got[i] !== item.rgb[i]) begin
                        $display("%0t: %s for wavelength %0d gain %0d: expected %0d, got %0d",
                                 $time, lane_names[i], item.wl, item.gain,
                                 item.rgb[i], got[i]);
                        mismatches++;
                    end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Range limits, every band edge, zero, unit and full-scale gains
    task automatic test_directed();
        logic [13:0] wls [24] = '{
            14'd0,     14'd6079,  14'd6080,  14'd6720,  14'd7040,  14'd7839,
            14'd7840,  14'd8160,  14'd9280,  14'd10320, 14'd12480, 14'd12481,
            14'd16383, 14'd8000,  14'd8000,  14'd8000,  14'd9800,  14'd9800,
            14'd6400,  14'd11000, 14'd7500,  14'd12480, 14'd6080,  14'd9279};
        logic [15:0] gains [24] = '{
            16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000,
            16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000,
            16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h1000, 16'hFFFF,
            16'h2000, 16'h3000, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0800};
        rx_style = RX_OPEN;
        for (int i = 0; i < 24; i++)
            send_beat(wls[i], gains[i]);
        pause_sender(1);
        wait_for_colours();
    endtask

    // Spectrum-weighted items, in chunks of randomly dense or sparse traffic
    task automatic test_spectrum();
        for (int chunk = 0; chunk < 12; chunk++) begin
            rx_style = ($urandom_range(0, 2) == 0) ? RX_OPEN : RX_CHOPPY;
            send_stream(100, ITEM_SPECTRUM, ($urandom_range(0, 1) == 0) ? 0 : 5);
        end
        wait_for_colours();
    endtask

    // Long receiver hold-off while the sender keeps offering beats
    task automatic test_backpressure();
        rx_style = RX_OPEN;
        hold_req = 1'b1;
        send_stream(60, ITEM_SPECTRUM, 0);
        wait_for_colours();
        rx_style = RX_CHOPPY;
        hold_req = 1'b1;
        send_stream(60, ITEM_SPECTRUM, 2);
        wait_for_colours();
    endtask

    // Fully random fields, out-of-range wavelengths included
    task automatic test_noise();
        rx_style = RX_CHOPPY;
        send_stream(200, ITEM_NOISE, 4);
        wait_for_colours();
    endtask

    initial
    begin : main
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_spectrum();
        test_backpressure();
        test_noise();

        if (mismatches == 0 && colour_queue.size() == 0)
            $display("** wavelength_to_rgb: PASSED **");
        else
            $display("** wavelength_to_rgb: FAILED **");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial
    begin : watchdog
        #2_000_000;
        $display("** wavelength_to_rgb: FAILED **");
        $finish;
    end

endmodule
